### hdl/ioc_pkg.sv
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared types and constants of the interlocked output controller.
// ----------------------------------------------------------------------------
package ioc_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd1;

    localparam logic [CFG_DATA_W-1:0] DEAD_TIME_RESET = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET   = 16'd1000;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_COMMAND   = 3'd1;
    localparam logic [2:0] OP_EMG_STOP  = 3'd2;
    localparam logic [2:0] OP_EMG_RESET = 3'd3;
    localparam logic [2:0] OP_LINK_LOST = 3'd4;

    localparam logic [7:0] MSG_LEN = 8'd5;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_CHAR = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_FAULT    = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] msg_length;
        logic [7:0] char_thumb;
        logic [7:0] char_index;
        logic [7:0] char_middle;
        logic [7:0] char_ring;
        logic [7:0] char_little;
    } t_cmd;

    typedef struct packed {
        logic       gripper_on;
        logic       inspector_on;
        logic       conveyor_on;
        logic       selector_on;
        logic       lock_on;
        logic       emergency_active;
        t_status    status;
    } t_res;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] dead_time_ticks;
        logic [CFG_DATA_W-1:0] timeout_ticks;
    } t_cfg;

endpackage

### hdl/ioc_if.sv
// ----------------------------------------------------------------------------
// ioc_if
// Handshake channels of the interlocked output controller.
// ----------------------------------------------------------------------------
interface ioc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] msg_length;
    logic [7:0] char_thumb;
    logic [7:0] char_index;
    logic [7:0] char_middle;
    logic [7:0] char_ring;
    logic [7:0] char_little;

    modport source (
        output valid, opcode, msg_length, char_thumb, char_index, char_middle,
               char_ring, char_little,
        input  ready
    );
    modport sink (
        input  valid, opcode, msg_length, char_thumb, char_index, char_middle,
               char_ring, char_little,
        output ready
    );
endinterface

interface ioc_res_if;
    logic       valid;
    logic       ready;
    logic       gripper_on;
    logic       inspector_on;
    logic       conveyor_on;
    logic       selector_on;
    logic       lock_on;
    logic       emergency_active;
    logic [2:0] status;

    modport source (
        output valid, gripper_on, inspector_on, conveyor_on, selector_on, lock_on,
               emergency_active, status,
        input  ready
    );
    modport sink (
        input  valid, gripper_on, inspector_on, conveyor_on, selector_on, lock_on,
               emergency_active, status,
        output ready
    );
endinterface

interface ioc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/interlocked_output_controller.sv
// ----------------------------------------------------------------------------
// interlocked_output_controller
// Gripper/inspector interlock with dead time, emergency latch and watchdog.
//
//   channel   dir   contents
//   i_cmd     in    opcode, msg_length, five command characters
//   o_res     out   five output levels, emergency_active, status
//   i_cfg     in    register index and 16-bit write data
//
// one item per cycle while the result sink accepts; an accepted item loads the input
// register, and then the result register once that register has space
// the state update is a single pass from the input register into the result
// register, gated only by space in the result register
// synchronous active-low reset clears state, valids and loads register defaults
// a stalled output blocks the input once the input register also holds an item
// ----------------------------------------------------------------------------
module interlocked_output_controller #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ioc_cmd_if.sink          i_cmd,
    ioc_res_if.source        o_res,
    ioc_cfg_if.sink          i_cfg
);
    import ioc_pkg::*;

    t_cmd in_cmd;
    t_cmd stage_cmd;
    t_cfg cfg;
    t_res core_res;
    t_res out_res;
    logic stage_valid;
    logic out_valid;
    logic fire;

    assign in_cmd.opcode      = i_cmd.opcode;
    assign in_cmd.msg_length  = i_cmd.msg_length;
    assign in_cmd.char_thumb  = i_cmd.char_thumb;
    assign in_cmd.char_index  = i_cmd.char_index;
    assign in_cmd.char_middle = i_cmd.char_middle;
    assign in_cmd.char_ring   = i_cmd.char_ring;
    assign in_cmd.char_little = i_cmd.char_little;

    assign fire = stage_valid && (!out_valid || o_res.ready);

    ioc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .o_wr_ready (i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    ioc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .o_ready   (i_cmd.ready),
        .i_cmd     (in_cmd),
        .i_advance (fire),
        .o_valid   (stage_valid),
        .o_cmd     (stage_cmd)
    );

    ioc_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (stage_cmd),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    ioc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (core_res),
        .i_ready (o_res.ready),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_res.valid            = out_valid;
    assign o_res.gripper_on       = out_res.gripper_on;
    assign o_res.inspector_on     = out_res.inspector_on;
    assign o_res.conveyor_on      = out_res.conveyor_on;
    assign o_res.selector_on      = out_res.selector_on;
    assign o_res.lock_on          = out_res.lock_on;
    assign o_res.emergency_active = out_res.emergency_active;
    assign o_res.status           = out_res.status;

endmodule

### hdl/ioc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ioc_cfg_regs
// Dead time and watchdog timeout registers.
// ----------------------------------------------------------------------------
module ioc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_valid,
    output logic                            o_wr_ready,
    input  logic [ioc_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [ioc_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output ioc_pkg::t_cfg                   o_cfg
);
    import ioc_pkg::*;

    logic [CFG_DATA_W-1:0] r_dead_time;
    logic [CFG_DATA_W-1:0] r_timeout;

    assign o_wr_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_time <= DEAD_TIME_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                REG_DEAD_TIME: r_dead_time <= i_wr_data;
                REG_TIMEOUT:   r_timeout   <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.dead_time_ticks = r_dead_time;
    assign o_cfg.timeout_ticks   = r_timeout;

endmodule

### hdl/ioc_in_stage.sv
// ----------------------------------------------------------------------------
// ioc_in_stage
// Input register holding one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module ioc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ioc_pkg::t_cmd i_cmd,
    input  logic          i_advance,
    output logic          o_valid,
    output ioc_pkg::t_cmd o_cmd
);
    import ioc_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

### hdl/ioc_core.sv
// ----------------------------------------------------------------------------
// ioc_core
// Interlock, emergency latch and watchdog state with single-pass update.
// ----------------------------------------------------------------------------
module ioc_core #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  ioc_pkg::t_cmd i_cmd,
    input  ioc_pkg::t_cfg i_cfg,
    output ioc_pkg::t_res o_res
);
    import ioc_pkg::*;

    localparam int unsigned CW    = COUNTER_WIDTH;
    localparam int unsigned CMP_W = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    logic          r_grip;
    logic          r_insp;
    logic          r_grip_req;
    logic          r_insp_req;
    logic [2:0]    r_direct;
    logic          r_emg;
    logic [CW-1:0] r_since_grip;
    logic [CW-1:0] r_since_insp;
    logic [CW-1:0] r_since_cmd;

    logic          n_grip;
    logic          n_insp;
    logic          n_grip_req;
    logic          n_insp_req;
    logic [2:0]    n_direct;
    logic          n_emg;
    logic [CW-1:0] n_since_grip;
    logic [CW-1:0] n_since_insp;
    logic [CW-1:0] n_since_cmd;
    t_status       n_status;

    logic          run_il;
    logic          il_stop;
    logic          chars_ok;
    logic [4:0]    bits;
    logic [39:0]   chars;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    always_comb begin
        n_grip       = r_grip;
        n_insp       = r_insp;
        n_grip_req   = r_grip_req;
        n_insp_req   = r_insp_req;
        n_direct     = r_direct;
        n_emg        = r_emg;
        n_since_grip = r_since_grip;
        n_since_insp = r_since_insp;
        n_since_cmd  = r_since_cmd;
        n_status     = ST_OK;
        run_il       = 1'b0;
        il_stop      = 1'b0;
        chars        = {i_cmd.char_little, i_cmd.char_ring, i_cmd.char_middle,
                        i_cmd.char_index, i_cmd.char_thumb};
        chars_ok     = 1'b1;
        bits         = '0;

        for (int k = 0; k < 5; k++) begin
            if (chars[8*k +: 8] != CH_ZERO && chars[8*k +: 8] != CH_ONE) begin
                chars_ok = 1'b0;
            end
            bits[k] = (chars[8*k +: 8] == CH_ONE);
        end

        unique case (i_cmd.opcode) inside
            OP_TICK: begin
                n_since_grip = sat_inc(r_since_grip);
                n_since_insp = sat_inc(r_since_insp);
                n_since_cmd  = sat_inc(r_since_cmd);
                run_il       = 1'b1;
            end
            OP_COMMAND: begin
                if (r_emg) begin
                    n_status = ST_IGNORED;
                end else if (i_cmd.msg_length != MSG_LEN) begin
                    n_status = ST_BAD_LEN;
                end else if (!chars_ok) begin
                    n_status = ST_BAD_CHAR;
                end else begin
                    n_since_cmd = '0;
                    n_grip_req  = bits[1];
                    n_insp_req  = bits[3];
                    n_direct    = {bits[4], bits[2], bits[0]};
                    run_il      = 1'b1;
                end
                if (!run_il) begin
                    n_grip       = 1'b0;
                    n_insp       = 1'b0;
                    n_direct     = '0;
                    n_since_grip = '0;
                    n_since_insp = '0;
                end
            end
            OP_EMG_STOP, OP_EMG_RESET, OP_LINK_LOST: begin
                if (i_cmd.opcode == OP_EMG_STOP) begin
                    n_emg      = 1'b1;
                    n_grip_req = 1'b0;
                    n_insp_req = 1'b0;
                end else if (i_cmd.opcode == OP_EMG_RESET) begin
                    n_emg       = 1'b0;
                    n_grip_req  = 1'b0;
                    n_insp_req  = 1'b0;
                    n_since_cmd = '0;
                end
                n_grip       = 1'b0;
                n_insp       = 1'b0;
                n_direct     = '0;
                n_since_grip = '0;
                n_since_insp = '0;
            end
            default: ;
        endcase

        // interlock update
        if (run_il) begin
            if (r_emg) begin
                n_grip = 1'b0;
                n_insp = 1'b0;
            end else begin
                if (n_grip && !n_grip_req) begin
                    n_grip       = 1'b0;
                    n_since_grip = '0;
                end
                if (n_insp && !n_insp_req) begin
                    n_insp       = 1'b0;
                    n_since_insp = '0;
                end
                if (n_grip_req) begin
                    if (n_insp) begin
                        n_grip  = 1'b0;
                        il_stop = 1'b1;
                    end else begin
                        n_grip = CMP_W'(n_since_insp) >= CMP_W'(i_cfg.dead_time_ticks);
                    end
                end
                if (n_insp_req && !il_stop) begin
                    if (n_grip) begin
                        n_insp  = 1'b0;
                        il_stop = 1'b1;
                    end else begin
                        n_insp = CMP_W'(n_since_grip) >= CMP_W'(i_cfg.dead_time_ticks);
                    end
                end
                if (!il_stop && n_grip && n_insp) begin
                    n_grip       = 1'b0;
                    n_insp       = 1'b0;
                    n_since_grip = '0;
                    n_since_insp = '0;
                    n_status     = ST_FAULT;
                end
            end
        end

        // watchdog and latch hold on ticks
        if (i_cmd.opcode == OP_TICK) begin
            if (r_emg || CMP_W'(n_since_cmd) > CMP_W'(i_cfg.timeout_ticks)) begin
                n_grip       = 1'b0;
                n_insp       = 1'b0;
                n_direct     = '0;
                n_since_grip = '0;
                n_since_insp = '0;
                if (!r_emg) begin
                    n_grip_req  = 1'b0;
                    n_insp_req  = 1'b0;
                    n_since_cmd = '0;
                    n_status    = ST_TIMEOUT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grip       <= 1'b0;
            r_insp       <= 1'b0;
            r_grip_req   <= 1'b0;
            r_insp_req   <= 1'b0;
            r_direct     <= '0;
            r_emg        <= 1'b0;
            r_since_grip <= '0;
            r_since_insp <= '0;
            r_since_cmd  <= '0;
        end else if (i_fire) begin
            r_grip       <= n_grip;
            r_insp       <= n_insp;
            r_grip_req   <= n_grip_req;
            r_insp_req   <= n_insp_req;
            r_direct     <= n_direct;
            r_emg        <= n_emg;
            r_since_grip <= n_since_grip;
            r_since_insp <= n_since_insp;
            r_since_cmd  <= n_since_cmd;
        end
    end

    assign o_res.gripper_on       = n_grip;
    assign o_res.inspector_on     = n_insp;
    assign o_res.conveyor_on      = n_direct[0];
    assign o_res.selector_on      = n_direct[1];
    assign o_res.lock_on          = n_direct[2];
    assign o_res.emergency_active = n_emg;
    assign o_res.status           = n_status;

endmodule

### hdl/ioc_out_stage.sv
// ----------------------------------------------------------------------------
// ioc_out_stage
// Result register holding one finished item until the sink takes it.
// ----------------------------------------------------------------------------
module ioc_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  ioc_pkg::t_res i_res,
    input  logic          i_ready,
    output logic          o_valid,
    output ioc_pkg::t_res o_res
);
    import ioc_pkg::*;

    logic r_valid;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hdl/ioc_checker.sv
// ----------------------------------------------------------------------------
// ioc_checker
// Port-level checks of the interlocked output controller.
// ----------------------------------------------------------------------------
module ioc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_gripper_on,
    input logic       i_inspector_on,
    input logic       i_conveyor_on,
    input logic       i_selector_on,
    input logic       i_lock_on,
    input logic       i_emergency_active,
    input logic [2:0] i_status
);
    import ioc_pkg::*;

    logic any_on;
    logic [8:0] res_bits;

    assign any_on = i_gripper_on | i_inspector_on | i_conveyor_on | i_selector_on | i_lock_on;
    assign res_bits = {i_gripper_on, i_inspector_on, i_conveyor_on, i_selector_on,
                       i_lock_on, i_emergency_active, i_status};

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_gripper_on && i_inspector_on))
        else $error("gripper and inspector both on");

    a_emg_all_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_emergency_active) |-> !any_on)
        else $error("output on while emergency latched");

    a_ignored_in_emg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status == ST_IGNORED) |-> i_emergency_active)
        else $error("command ignored without emergency");

    a_timeout_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status == ST_TIMEOUT) |-> (!any_on && !i_emergency_active))
        else $error("timeout item with output on");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(res_bits)))
        else $error("stalled result item changed");

endmodule

bind interlocked_output_controller ioc_checker u_ioc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_gripper_on       (o_res.gripper_on),
    .i_inspector_on     (o_res.inspector_on),
    .i_conveyor_on      (o_res.conveyor_on),
    .i_selector_on      (o_res.selector_on),
    .i_lock_on          (o_res.lock_on),
    .i_emergency_active (o_res.emergency_active),
    .i_status           (o_res.status)
);
